/* rtl/segment_intersection_defines.svh */
// ----------------------------------------------------------------------------
// segment_intersection_defines
// Assertion macros shared by the segment intersection modules.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define SI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define SI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/si_pkg.sv */
// ----------------------------------------------------------------------------
// si_pkg
// Shared constants and types for the segment intersection block.
// ----------------------------------------------------------------------------
package si_pkg;

    // Default coordinate width (signed fixed point)
    localparam int COORD_BITS_DEF = 20;
    // Default result coordinate width (signed fixed point)
    localparam int OUT_BITS_DEF   = 32;
    // Entries in the queue between classifier and divider
    localparam int FIFO_DEPTH     = 4;

    // Classification flags carried with each request
    typedef struct packed {
        logic parallel;
        logic line_meets;
        logic seg_meet;
    } si_flags_t;

endpackage

/* rtl/si_front.sv */
// ----------------------------------------------------------------------------
// si_front
// Five-stage classifier: orientation signs, determinant and the two
// intersection numerators, all exact.
// ----------------------------------------------------------------------------
module si_front #(
    parameter int COORD_BITS = si_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  a_start_x,
    input  logic signed [COORD_BITS-1:0]  a_start_y,
    input  logic signed [COORD_BITS-1:0]  a_end_x,
    input  logic signed [COORD_BITS-1:0]  a_end_y,
    input  logic signed [COORD_BITS-1:0]  b_start_x,
    input  logic signed [COORD_BITS-1:0]  b_start_y,
    input  logic signed [COORD_BITS-1:0]  b_end_x,
    input  logic signed [COORD_BITS-1:0]  b_end_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output si_pkg::si_flags_t             out_flags,
    output logic signed [2*COORD_BITS+2:0] out_det,
    output logic signed [3*COORD_BITS+2:0] out_xn,
    output logic signed [3*COORD_BITS+2:0] out_yn
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int MW = 2 * COORD_BITS;
    localparam int CW = MW + 1;
    localparam int QW = CW + DW;
    localparam int NW = QW + 1;

    logic en;

    // Stage 1: differences and raw points
    logic                         v1_reg;
    logic signed [DW-1:0]         ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [DW-1:0]         pdx_reg [4];
    logic signed [DW-1:0]         pdy_reg [4];
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [COORD_BITS-1:0] x3_reg, y3_reg, x4_reg, y4_reg;

    // Stage 2: products
    logic                         v2_reg;
    logic signed [PW-1:0]         psa_reg [4];
    logic signed [PW-1:0]         psb_reg [4];
    logic signed [PW-1:0]         pd0_reg, pd1_reg;
    logic signed [MW-1:0]         pc_reg [4];
    logic signed [DW-1:0]         ax2_reg, ay2_reg, bx2_reg, by2_reg;

    // Stage 3: signs, determinant, cross terms
    logic                         v3_reg;
    si_pkg::si_flags_t            f3_reg;
    logic signed [SW-1:0]         det3_reg;
    logic signed [CW-1:0]         c12_reg, c34_reg;
    logic signed [DW-1:0]         ax3_reg, ay3_reg, bx3_reg, by3_reg;
    logic signed [SW-1:0]         side_w [4];
    logic signed [SW-1:0]         det_w;
    logic                         pos_w [4];
    logic                         neg_w [4];
    logic                         hit_a_w, hit_b_w;

    // Stage 4: numerator products
    logic                         v4_reg;
    si_pkg::si_flags_t            f4_reg;
    logic signed [SW-1:0]         det4_reg;
    logic signed [QW-1:0]         pn_reg [4];

    // Stage 5: numerators
    logic                         v5_reg;
    si_pkg::si_flags_t            f5_reg;
    logic signed [SW-1:0]         det5_reg;
    logic signed [NW-1:0]         xn5_reg, yn5_reg;

    // Stall the whole pipe only when the last stage cannot leave
    assign en       = !v5_reg || out_ready;
    assign in_ready = en;

    // Classify from the side values
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            side_w[k] = SW'(psa_reg[k]) - SW'(psb_reg[k]);
            neg_w[k]  = side_w[k][SW-1];
            pos_w[k]  = !side_w[k][SW-1] && (side_w[k] != '0);
        end
        det_w   = SW'(pd0_reg) - SW'(pd1_reg);
        hit_a_w = !((pos_w[0] && pos_w[1]) || (neg_w[0] && neg_w[1]));
        hit_b_w = !((pos_w[2] && pos_w[3]) || (neg_w[2] && neg_w[3]));
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            ax_reg     <= DW'(a_end_x) - DW'(a_start_x);
            ay_reg     <= DW'(a_end_y) - DW'(a_start_y);
            bx_reg     <= DW'(b_end_x) - DW'(b_start_x);
            by_reg     <= DW'(b_end_y) - DW'(b_start_y);
            pdx_reg[0] <= DW'(b_start_x) - DW'(a_start_x);
            pdy_reg[0] <= DW'(b_start_y) - DW'(a_start_y);
            pdx_reg[1] <= DW'(b_end_x) - DW'(a_start_x);
            pdy_reg[1] <= DW'(b_end_y) - DW'(a_start_y);
            pdx_reg[2] <= DW'(a_start_x) - DW'(b_start_x);
            pdy_reg[2] <= DW'(a_start_y) - DW'(b_start_y);
            pdx_reg[3] <= DW'(a_end_x) - DW'(b_start_x);
            pdy_reg[3] <= DW'(a_end_y) - DW'(b_start_y);
            x1_reg     <= a_start_x;
            y1_reg     <= a_start_y;
            x2_reg     <= a_end_x;
            y2_reg     <= a_end_y;
            x3_reg     <= b_start_x;
            y3_reg     <= b_start_y;
            x4_reg     <= b_end_x;
            y4_reg     <= b_end_y;

            // stage 2
            for (int k = 0; k < 2; k++)
            begin
                psa_reg[k]   <= PW'(pdx_reg[k]) * PW'(ay_reg);
                psb_reg[k]   <= PW'(pdy_reg[k]) * PW'(ax_reg);
                psa_reg[k+2] <= PW'(pdx_reg[k+2]) * PW'(by_reg);
                psb_reg[k+2] <= PW'(pdy_reg[k+2]) * PW'(bx_reg);
            end
            pd0_reg   <= PW'(ax_reg) * PW'(by_reg);
            pd1_reg   <= PW'(ay_reg) * PW'(bx_reg);
            pc_reg[0] <= MW'(x1_reg) * MW'(y2_reg);
            pc_reg[1] <= MW'(y1_reg) * MW'(x2_reg);
            pc_reg[2] <= MW'(x3_reg) * MW'(y4_reg);
            pc_reg[3] <= MW'(y3_reg) * MW'(x4_reg);
            ax2_reg   <= ax_reg;
            ay2_reg   <= ay_reg;
            bx2_reg   <= bx_reg;
            by2_reg   <= by_reg;

            // stage 3
            f3_reg.parallel   <= (det_w == '0);
            f3_reg.line_meets <= hit_a_w;
            f3_reg.seg_meet   <= hit_a_w && hit_b_w;
            det3_reg          <= det_w;
            c12_reg           <= CW'(pc_reg[0]) - CW'(pc_reg[1]);
            c34_reg           <= CW'(pc_reg[2]) - CW'(pc_reg[3]);
            ax3_reg           <= ax2_reg;
            ay3_reg           <= ay2_reg;
            bx3_reg           <= bx2_reg;
            by3_reg           <= by2_reg;

            // stage 4
            f4_reg    <= f3_reg;
            det4_reg  <= det3_reg;
            pn_reg[0] <= QW'(ax3_reg) * QW'(c34_reg);
            pn_reg[1] <= QW'(c12_reg) * QW'(bx3_reg);
            pn_reg[2] <= QW'(ay3_reg) * QW'(c34_reg);
            pn_reg[3] <= QW'(c12_reg) * QW'(by3_reg);

            // stage 5
            f5_reg   <= f4_reg;
            det5_reg <= det4_reg;
            xn5_reg  <= NW'(pn_reg[0]) - NW'(pn_reg[1]);
            yn5_reg  <= NW'(pn_reg[2]) - NW'(pn_reg[3]);
        end
    end

    assign out_valid = v5_reg;
    assign out_flags = f5_reg;
    assign out_det   = det5_reg;
    assign out_xn    = xn5_reg;
    assign out_yn    = yn5_reg;

endmodule

/* rtl/si_fifo.sv */
// ----------------------------------------------------------------------------
// si_fifo
// Short register queue between the classifier and the divider.
// ----------------------------------------------------------------------------
`include "segment_intersection_defines.svh"

module si_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = si_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CNTW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Hold request payloads
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

    `SI_ASSERT_NOW(a_cnt_max, 1'b1, count_reg <= CNTW'(DEPTH), "fifo count above depth")
    `SI_ASSERT_NEXT(a_cnt_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "fifo count lost a push")

endmodule

/* rtl/si_back.sv */
// ----------------------------------------------------------------------------
// si_back
// Pipelined restoring divider for both coordinates, saturation and the
// output register.
// ----------------------------------------------------------------------------
`include "segment_intersection_defines.svh"

module si_back #(
    parameter int COORD_BITS = si_pkg::COORD_BITS_DEF,
    parameter int OUT_BITS   = si_pkg::OUT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  si_pkg::si_flags_t              in_flags,
    input  logic signed [2*COORD_BITS+2:0] in_det,
    input  logic signed [3*COORD_BITS+2:0] in_xn,
    input  logic signed [3*COORD_BITS+2:0] in_yn,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           parallel,
    output logic                           line_meets_segment,
    output logic                           segments_meet,
    output logic signed [OUT_BITS-1:0]     cross_x,
    output logic signed [OUT_BITS-1:0]     cross_y,
    output logic                           point_overflow
);

    localparam int SW = 2 * COORD_BITS + 3;
    localparam int NW = 3 * COORD_BITS + 3;
    localparam int XW = (NW > SW + OUT_BITS) ? NW : SW + OUT_BITS;
    localparam logic [OUT_BITS-1:0] SAT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] SAT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    logic en;
    logic signed [NW-1:0] n_w [2];
    logic [NW-1:0]        mag_w [2];
    logic [SW-1:0]        magd_w;

    // Magnitude stage
    logic                 b0_v_reg;
    si_pkg::si_flags_t    b0_f_reg;
    logic                 b0_neg_reg [2];
    logic [NW-1:0]        b0_magn_reg [2];
    logic [SW-1:0]        b0_magd_reg;

    // Overflow check and remainder seed
    logic [XW-1:0]        ext_w [2];
    logic [XW-1:0]        shr_w [2];
    logic                 big_w [2];

    // Division stages, index 0 is the seed
    logic                 dv_reg   [OUT_BITS+1];
    si_pkg::si_flags_t    df_reg   [OUT_BITS+1];
    logic                 dneg_reg [OUT_BITS+1][2];
    logic                 dovf_reg [OUT_BITS+1][2];
    logic [SW-1:0]        dd_reg   [OUT_BITS+1];
    logic [SW-1:0]        dr_reg   [OUT_BITS+1][2];
    logic [OUT_BITS-1:0]  dq_reg   [OUT_BITS+1][2];
    logic [OUT_BITS-1:0]  dn_reg   [OUT_BITS+1][2];
    logic [SW:0]          t_w      [OUT_BITS][2];
    logic [SW:0]          ts_w     [OUT_BITS][2];
    logic                 ge_w     [OUT_BITS][2];

    // Saturation
    logic [OUT_BITS-1:0]  q_w   [2];
    logic                 ovf_w [2];
    logic [OUT_BITS-1:0]  val_w [2];

    // Output register
    logic                 out_valid_reg;
    logic                 parallel_reg, line_reg, seg_reg, ovf_reg;
    logic [OUT_BITS-1:0]  cross_x_reg, cross_y_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Take magnitudes and quotient signs
    assign n_w[0] = in_xn;
    assign n_w[1] = in_yn;
    assign magd_w = in_det[SW-1] ? SW'(-in_det) : SW'(in_det);

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag_w[l] = n_w[l][NW-1] ? NW'(-n_w[l]) : NW'(n_w[l]);
            ext_w[l] = XW'(b0_magn_reg[l]);
            shr_w[l] = ext_w[l] >> OUT_BITS;
            big_w[l] = ext_w[l] >= (XW'(b0_magd_reg) << OUT_BITS);
        end
    end

    // One quotient bit per stage and lane
    always_comb
    begin
        for (int k = 0; k < OUT_BITS; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                t_w[k][l]  = {dr_reg[k][l], dn_reg[k][l][OUT_BITS-1]};
                ts_w[k][l] = t_w[k][l] - {1'b0, dd_reg[k]};
                ge_w[k][l] = t_w[k][l] >= {1'b0, dd_reg[k]};
            end
        end
    end

    // Saturate the final quotients
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            q_w[l]   = dq_reg[OUT_BITS][l];
            ovf_w[l] = dovf_reg[OUT_BITS][l] ||
                       (dneg_reg[OUT_BITS][l] ? (q_w[l][OUT_BITS-1] && (|q_w[l][OUT_BITS-2:0]))
                                              : q_w[l][OUT_BITS-1]);
            if (ovf_w[l])
                val_w[l] = dneg_reg[OUT_BITS][l] ? SAT_MIN : SAT_MAX;
            else
                val_w[l] = dneg_reg[OUT_BITS][l] ? -q_w[l] : q_w[l];
        end
    end

    // Advance valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= OUT_BITS; k++)
                dv_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            b0_v_reg  <= in_valid;
            dv_reg[0] <= b0_v_reg;
            for (int k = 0; k < OUT_BITS; k++)
                dv_reg[k+1] <= dv_reg[k];
            out_valid_reg <= dv_reg[OUT_BITS];
        end
    end

    // Advance payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_f_reg    <= in_flags;
            b0_magd_reg <= magd_w;
            for (int l = 0; l < 2; l++)
            begin
                b0_magn_reg[l] <= mag_w[l];
                b0_neg_reg[l]  <= n_w[l][NW-1] ^ in_det[SW-1];
            end

            df_reg[0] <= b0_f_reg;
            dd_reg[0] <= b0_magd_reg;
            for (int l = 0; l < 2; l++)
            begin
                dneg_reg[0][l] <= b0_neg_reg[l];
                dovf_reg[0][l] <= big_w[l];
                dr_reg[0][l]   <= shr_w[l][SW-1:0];
                dq_reg[0][l]   <= '0;
                dn_reg[0][l]   <= ext_w[l][OUT_BITS-1:0];
            end

            for (int k = 0; k < OUT_BITS; k++)
            begin
                df_reg[k+1] <= df_reg[k];
                dd_reg[k+1] <= dd_reg[k];
                for (int l = 0; l < 2; l++)
                begin
                    dneg_reg[k+1][l] <= dneg_reg[k][l];
                    dovf_reg[k+1][l] <= dovf_reg[k][l];
                    dr_reg[k+1][l]   <= ge_w[k][l] ? ts_w[k][l][SW-1:0] : t_w[k][l][SW-1:0];
                    dq_reg[k+1][l]   <= {dq_reg[k][l][OUT_BITS-2:0], ge_w[k][l]};
                    dn_reg[k+1][l]   <= {dn_reg[k][l][OUT_BITS-2:0], 1'b0};
                end
            end

            parallel_reg <= df_reg[OUT_BITS].parallel;
            line_reg     <= df_reg[OUT_BITS].line_meets;
            seg_reg      <= df_reg[OUT_BITS].seg_meet;
            if (df_reg[OUT_BITS].parallel)
            begin
                cross_x_reg <= '0;
                cross_y_reg <= '0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                cross_x_reg <= val_w[0];
                cross_y_reg <= val_w[1];
                ovf_reg     <= ovf_w[0] || ovf_w[1];
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign parallel           = parallel_reg;
    assign line_meets_segment = line_reg;
    assign segments_meet      = seg_reg;
    assign cross_x            = cross_x_reg;
    assign cross_y            = cross_y_reg;
    assign point_overflow     = ovf_reg;

    `SI_ASSERT_NOW(a_par_zero, out_valid_reg && parallel_reg, (cross_x_reg == '0) && (cross_y_reg == '0) && !ovf_reg, "parallel result with a point")
    `SI_ASSERT_NOW(a_seg_line, out_valid_reg && seg_reg, line_reg, "segments meet without line test")
    `SI_ASSERT_NOW(a_ovf_sat, out_valid_reg && ovf_reg, (cross_x_reg == SAT_MAX) || (cross_x_reg == SAT_MIN) || (cross_y_reg == SAT_MAX) || (cross_y_reg == SAT_MIN), "overflow without saturation")

endmodule

/* rtl/segment_intersection.sv */
// ----------------------------------------------------------------------------
// segment_intersection
// Two-segment intersection test with exact signs and a saturated
// line-line intersection point.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid/in_ready) takes one request per cycle: the two
//   end points of segment A and of segment B, signed fixed point.
// - Output channel (out_valid/out_ready) returns one result per request, in
//   order: parallel, line_meets_segment, segments_meet, cross_x, cross_y and
//   point_overflow. The point is zero when the lines are parallel.
// - From accept to out_valid a request passes five classifier stages, the
//   queue, two divider set-up stages, one divider stage per quotient bit
//   and one output stage.
// - Throughput: one request per cycle if unstalled; divider fully pipelined.
// - A stalled receiver freezes the divider pipe; the classifier keeps
//   running until the four-entry queue fills, then in_ready drops.
// - Reset clears all valids and queue pointers; no request is pending after
//   reset, and the payload registers are not reset.
// ----------------------------------------------------------------------------
module segment_intersection #(
    parameter int COORD_BITS = si_pkg::COORD_BITS_DEF,
    parameter int OUT_BITS   = si_pkg::OUT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  a_start_x,
    input  logic signed [COORD_BITS-1:0]  a_start_y,
    input  logic signed [COORD_BITS-1:0]  a_end_x,
    input  logic signed [COORD_BITS-1:0]  a_end_y,
    input  logic signed [COORD_BITS-1:0]  b_start_x,
    input  logic signed [COORD_BITS-1:0]  b_start_y,
    input  logic signed [COORD_BITS-1:0]  b_end_x,
    input  logic signed [COORD_BITS-1:0]  b_end_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          parallel,
    output logic                          line_meets_segment,
    output logic                          segments_meet,
    output logic signed [OUT_BITS-1:0]    cross_x,
    output logic signed [OUT_BITS-1:0]    cross_y,
    output logic                          point_overflow
);

    localparam int SW = 2 * COORD_BITS + 3;
    localparam int NW = 3 * COORD_BITS + 3;
    localparam int EW = 3 + SW + 2 * NW;

    logic                  f_valid, f_ready;
    si_pkg::si_flags_t     f_flags;
    logic signed [SW-1:0]  f_det;
    logic signed [NW-1:0]  f_xn, f_yn;

    logic                  q_valid, q_ready;
    logic [EW-1:0]         q_in, q_out;
    si_pkg::si_flags_t     q_flags;
    logic signed [SW-1:0]  q_det;
    logic signed [NW-1:0]  q_xn, q_yn;

    // Classifier
    si_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_flags (f_flags),
        .out_det   (f_det),
        .out_xn    (f_xn),
        .out_yn    (f_yn)
    );

    // Pack and unpack queue entries
    assign q_in = {f_flags, f_det, f_xn, f_yn};
    assign {q_flags, q_det, q_xn, q_yn} = q_out;

    si_fifo #(
        .WIDTH (EW),
        .DEPTH (si_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out)
    );

    // Divider and output stage
    si_back #(
        .COORD_BITS (COORD_BITS),
        .OUT_BITS   (OUT_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (q_valid),
        .in_ready           (q_ready),
        .in_flags           (q_flags),
        .in_det             (q_det),
        .in_xn              (q_xn),
        .in_yn              (q_yn),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .parallel           (parallel),
        .line_meets_segment (line_meets_segment),
        .segments_meet      (segments_meet),
        .cross_x            (cross_x),
        .cross_y            (cross_y),
        .point_overflow     (point_overflow)
    );

endmodule

/* tb/segment_intersection_test.sv */
// ----------------------------------------------------------------------------
// segment_intersection_test
// Drives segment pairs through the intersection block and checks every
// result against a predictor that works in exact wide integer arithmetic.
// ----------------------------------------------------------------------------
module segment_intersection_test;

    localparam int CB = si_pkg::COORD_BITS_DEF;
    localparam int OB = si_pkg::OUT_BITS_DEF;
    localparam int LATENCY = OB + 9;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct packed {
        logic                 parallel;
        logic                 line_meets;
        logic                 seg_meet;
        logic signed [OB-1:0] px;
        logic signed [OB-1:0] py;
        logic                 ovf;
    } answer_t;

    // Predicts each answer and holds it until the block returns one
    class intersection_board;
        answer_t pending[$];
        int      errors;

        function int orient(longint x1, longint y1, longint x2, longint y2,
                            longint sx, longint sy);
            logic signed [127:0] d;
            d = 128'(sx - x1) * 128'(y2 - y1) - 128'(sy - y1) * 128'(x2 - x1);
            return (d < 0) ? -1 : ((d == 0) ? 0 : 1);
        endfunction

        function logic signed [OB-1:0] clamp(logic signed [127:0] q,
                                             inout logic ovf);
            logic signed [127:0] top, bot;
            top = (128'sd1 <<< (OB - 1)) - 1;
            bot = -(128'sd1 <<< (OB - 1));
            if (q > top)
            begin
                ovf = 1'b1;
                q = top;
            end
            else if (q < bot)
            begin
                ovf = 1'b1;
                q = bot;
            end
            return q[OB-1:0];
        endfunction

        // Note an accepted request: work out its answer
        function void note_request(coord_t p[8]);
            longint x1, y1, x2, y2, x3, y3, x4, y4, c12, c34;
            logic signed [127:0] det, xn, yn;
            answer_t a;
            x1 = p[0]; y1 = p[1]; x2 = p[2]; y2 = p[3];
            x3 = p[4]; y3 = p[5]; x4 = p[6]; y4 = p[7];
            a = '0;
            a.line_meets = !(orient(x1, y1, x2, y2, x3, y3) *
                             orient(x1, y1, x2, y2, x4, y4) > 0);
            a.seg_meet = a.line_meets && !(orient(x3, y3, x4, y4, x1, y1) *
                                           orient(x3, y3, x4, y4, x2, y2) > 0);
            det = 128'(x1 - x2) * 128'(y3 - y4) - 128'(y1 - y2) * 128'(x3 - x4);
            a.parallel = (det == 0);
            if (!a.parallel)
            begin
                c12 = x1 * y2 - y1 * x2;
                c34 = x3 * y4 - y3 * x4;
                xn = 128'(c12) * 128'(x3 - x4) - 128'(x1 - x2) * 128'(c34);
                yn = 128'(c12) * 128'(y3 - y4) - 128'(y1 - y2) * 128'(c34);
                a.px = clamp(xn / det, a.ovf);
                a.py = clamp(yn / det, a.ovf);
            end
            pending.push_back(a);
        endfunction

        // Check a returned result against the oldest answer
        function void check_result(answer_t got);
            answer_t e;
            if (pending.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.parallel !== e.parallel)
            begin
                $error("parallel: expected %0d actual %0d", e.parallel, got.parallel);
                errors++;
            end
            if (got.line_meets !== e.line_meets)
            begin
                $error("line_meets_segment: expected %0d actual %0d",
                       e.line_meets, got.line_meets);
                errors++;
            end
            if (got.seg_meet !== e.seg_meet)
            begin
                $error("segments_meet: expected %0d actual %0d", e.seg_meet, got.seg_meet);
                errors++;
            end
            if (got.px !== e.px)
            begin
                $error("cross_x: expected %0d actual %0d", e.px, got.px);
                errors++;
            end
            if (got.py !== e.py)
            begin
                $error("cross_y: expected %0d actual %0d", e.py, got.py);
                errors++;
            end
            if (got.ovf !== e.ovf)
            begin
                $error("point_overflow: expected %0d actual %0d", e.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    coord_t pts[8];
    logic out_valid;
    logic out_ready = 1'b0;
    logic parallel, line_meets_segment, segments_meet, point_overflow;
    logic signed [OB-1:0] cross_x, cross_y;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    intersection_board board = new();

    always #5 clk = ~clk;

    segment_intersection dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_start_x(pts[0]), .a_start_y(pts[1]), .a_end_x(pts[2]), .a_end_y(pts[3]),
        .b_start_x(pts[4]), .b_start_y(pts[5]), .b_end_x(pts[6]), .b_end_y(pts[7]),
        .out_valid(out_valid), .out_ready(out_ready),
        .parallel(parallel), .line_meets_segment(line_meets_segment),
        .segments_meet(segments_meet), .cross_x(cross_x), .cross_y(cross_y),
        .point_overflow(point_overflow)
    );

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_request(pts);
        if (rst_n && out_valid && out_ready)
            board.check_result({parallel, line_meets_segment, segments_meet,
                                cross_x, cross_y, point_overflow});
    end

    // Receiver stalls, redrawn on each falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Present one request and hold it until accepted; valid stays up after
    // acceptance so the next request can follow straight on
    task automatic send_request(coord_t p[8]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        pts = p;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom_range(1));
            1: return {1'b0, {(CB-1){1'b1}}} - coord_t'($urandom_range(3));
            2: return {1'b1, {(CB-1){1'b0}}} + coord_t'($urandom_range(3));
            3: return coord_t'(int'($urandom_range(4095)) - 2048);
            default: return coord_t'($urandom());
        endcase
    endfunction

    // Random pair, sometimes shaped to be parallel, degenerate or touching
    task automatic send_random();
        coord_t p[8];
        foreach (p[i])
            p[i] = rand_coord();
        case ($urandom_range(9))
            0:
            begin
                p[6] = p[4] + (p[2] - p[0]);
                p[7] = p[5] + (p[3] - p[1]);
            end
            1:
            begin
                p[2] = p[0];
                p[3] = p[1];
            end
            2:
            begin
                p[4] = p[2];
                p[5] = p[3];
            end
            default: ;
        endcase
        send_request(p);
    endtask

    task automatic send_pts(int v0, int v1, int v2, int v3, int v4, int v5, int v6, int v7);
        coord_t p[8];
        p = '{coord_t'(v0), coord_t'(v1), coord_t'(v2), coord_t'(v3),
              coord_t'(v4), coord_t'(v5), coord_t'(v6), coord_t'(v7)};
        send_request(p);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    // Main sequence
    initial
    begin
        int mx, mn;
        foreach (pts[i])
            pts[i] = '0;
        mx = (1 << (CB - 1)) - 1;
        mn = -(1 << (CB - 1));
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: crossing, touching, parallel, collinear, degenerate, extremes
        send_pts(0, 0, 256, 256, 0, 256, 256, 0);
        send_pts(0, 0, 256, 0, 256, 0, 512, 256);
        send_pts(0, 0, 256, 0, 0, 256, 256, 256);
        send_pts(0, 0, 512, 0, 256, 0, 768, 0);
        send_pts(5, 5, 5, 5, 0, 0, 256, 256);
        send_pts(0, 0, 256, 256, 7, 9, 7, 9);
        send_pts(0, 0, 256, 0, 0, 256, 256, 512);
        send_pts(0, 0, 1, 1000, 0, 1, 1, 0);
        send_pts(mn, mn, mx, mx, mn, mx, mx, mn);
        send_pts(mx, mx, mn, mn, mx, mn, mn, mx);
        send_pts(mn, 0, mx, 1, mn, 1, mx, 0);
        send_pts(mn, mn, mx, mx - 1, mn, mn + 1, mx, mx);
        send_pts(0, 0, 1, 0, mx, mn, mx, mx);
        send_pts(mx, mx, mx, mx, mx, mx, mx, mx);
        send_pts(mn, mn, mn, mn, mn, mn, mn, mn);
        send_pts(-1, -1, -1, -1, -1, -1, -1, -1);
        send_pts(0, 0, 256, 256, 256, 0, 512, 256);

        // Let everything come back before starting random traffic
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            repeat (333)
                send_random();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        drain();
        repeat (LATENCY + 10) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Timeout
    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/si_pkg.sv
rtl/si_front.sv
rtl/si_fifo.sv
rtl/si_back.sv
rtl/segment_intersection.sv
tb/segment_intersection_test.sv
